### rtl/core/stabilizer_tableau_gate_engine_unit_macros.svh
// Assertion macros shared by the tableau engine RTL.
// Both expect clk and arst_n in scope.
`ifndef STABILIZER_TABLEAU_GATE_ENGINE_UNIT_MACROS_SVH
`define STABILIZER_TABLEAU_GATE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SGE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SGE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/stgate_pkg.sv
`timescale 1ns / 1ps
package stgate_pkg;

	localparam int REQ_W       = 4;
	localparam int QF_W        = 4;
	localparam int ROW_F_W     = 5;
	localparam int ROWB_W      = 16;
	localparam int ROWB_IDX_W  = 4;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * ROWB_W - 1;
	localparam int STEP_W      = 3;

	typedef enum logic [REQ_W-1:0] {
		RQ_H    = 4'd0,
		RQ_P    = 4'd1,
		RQ_X    = 4'd2,
		RQ_Y    = 4'd3,
		RQ_Z    = 4'd4,
		RQ_CNOT = 4'd5,
		RQ_CZ   = 4'd6,
		RQ_INIT = 4'd7,
		RQ_READ = 4'd8
	} req_kind_t;

	typedef enum logic [1:0] {
		PR_H,
		PR_P,
		PR_CX
	} prim_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXEC,
		ST_WRT,
		ST_WRC,
		ST_SWEEP,
		ST_FIN
	} state_t;

	// Index of the final primitive step of each gate program
	function automatic logic [STEP_W-1:0] prog_last(req_kind_t k);
		logic [STEP_W-1:0] n;
		unique case (k)
			RQ_Z:    n = 3'd1;
			RQ_X:    n = 3'd3;
			RQ_Y:    n = 3'd5;
			RQ_CZ:   n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Z = P P, X = H P P H, Y = X Z, CZ = H(t) CNOT H(t)
	function automatic prim_t prog_step(req_kind_t k, logic [STEP_W-1:0] i);
		prim_t p;
		unique case (k) inside
			RQ_P, RQ_Z: p = PR_P;
			RQ_X, RQ_Y: p = (i == 3'd0 || i == 3'd3) ? PR_H : PR_P;
			RQ_CNOT:    p = PR_CX;
			RQ_CZ:      p = (i == 3'd1) ? PR_CX : PR_H;
			default:    p = PR_H;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/stabilizer_tableau_gate_engine_unit.sv
// An accepted gate is loaded, runs its S primitive steps and is written back, then its
// result goes to the output register (S primitive steps: H,P,CNOT 1, Z 2, CZ 3, X 4, Y 6;
// CNOT and CZ add one write-back). A row read sweeps min(NQ,16) columns: the column
// memories give one column per port per cycle. A new request is taken only in idle, once
// the last result is in the output register. Reset: tableau reads as identity via
// per-column valid flags, no clearing pass; phases cleared, output empty.
`timescale 1ns / 1ps
`include "stabilizer_tableau_gate_engine_unit_macros.svh"
module stabilizer_tableau_gate_engine_unit
	import stgate_pkg::*;
#(
	parameter int NQ = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// target_qubit[3:0], control_qubit[7:4], row_index[12:8], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// req_type[3:0]
	input  logic [REQ_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// row_z_bits[15:0], row_x_bits[31:16], row_phase[32], zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// bad_request[0]
	output logic [0:0]             m_tuser
);

	localparam int ROWS = 2 * NQ;
	localparam int QW   = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int RW   = $clog2(ROWS);
	localparam int NR   = (NQ < ROWB_W) ? NQ : ROWB_W;
	localparam int SW   = $clog2(NR + 1);
	localparam logic [5:0] NQ_V   = 6'(NQ);
	localparam logic [6:0] ROWS_V = 7'(ROWS);
	localparam logic [SW-1:0] NR_V = SW'(NR);

	state_t            st_q, st_nx;
	req_kind_t         kind_q, kind_in;
	logic [QW-1:0]     tq_q, cq_q;
	logic [RW-1:0]     row_q;
	logic [STEP_W-1:0] stp_q, stp_last;
	logic [SW-1:0]     sw_q;
	logic [ROWS-1:0]   zt_q, xt_q, zc_q, xc_q, ph_q;
	logic [ROWS-1:0]   zt_nx, xt_nx, zc_nx, ph_nx;
	logic [ROWB_W-1:0] rz_q, rx_q;
	logic              rph_q, bad_q;
	logic              mvld_q;
	logic [OUT_TDATA_W-1:0] mdata_q;
	logic              muser_q;

	logic [QF_W-1:0]    tq_in, cq_in;
	logic [ROW_F_W-1:0] row_in;
	logic               tq_ok, cq_ok, row_ok, bad_in, acc;
	prim_t              prim;

	logic [QW-1:0]   ra_a, ra_b, wa;
	logic            mem_we, mem_clr;
	logic [ROWS-1:0] wd_z, wd_x, z_rd_a, z_rd_b, x_rd_a, x_rd_b;

	assign tq_in   = s_tdata[3:0];
	assign cq_in   = s_tdata[7:4];
	assign row_in  = s_tdata[12:8];
	assign kind_in = req_kind_t'(s_tuser);
	assign acc     = s_tvalid && s_tready;

	assign tq_ok  = {2'b00, tq_in} < NQ_V;
	assign cq_ok  = {2'b00, cq_in} < NQ_V;
	assign row_ok = {2'b00, row_in} < ROWS_V;

	always_comb begin
		unique case (kind_in) inside
			RQ_H, RQ_P, RQ_X, RQ_Y, RQ_Z: bad_in = !tq_ok;
			RQ_CNOT, RQ_CZ:               bad_in = !(tq_ok && cq_ok && tq_in != cq_in);
			RQ_INIT:                      bad_in = 1'b0;
			RQ_READ:                      bad_in = !row_ok;
			default:                      bad_in = 1'b1;
		endcase
	end

	// Next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					if (bad_in || kind_in == RQ_INIT) begin
						st_nx = ST_FIN;
					end else if (kind_in == RQ_READ) begin
						st_nx = ST_SWEEP;
					end else begin
						st_nx = ST_LOAD;
					end
				end
			end
			ST_LOAD:  st_nx = ST_EXEC;
			ST_EXEC:  st_nx = (stp_q == stp_last) ? ST_WRT : ST_EXEC;
			ST_WRT:   st_nx = (kind_q == RQ_CNOT || kind_q == RQ_CZ) ? ST_WRC : ST_FIN;
			ST_WRC:   st_nx = ST_FIN;
			ST_SWEEP: st_nx = (sw_q == NR_V) ? ST_FIN : ST_SWEEP;
			ST_FIN:   st_nx = (!mvld_q || m_tready) ? ST_IDLE : ST_FIN;
			default:  st_nx = ST_IDLE;
		endcase
	end

	// State outputs: handshake and memory ports
	always_comb begin
		s_tready = 1'b0;
		ra_a     = QW'(tq_in);
		ra_b     = QW'(cq_in);
		mem_we   = 1'b0;
		mem_clr  = 1'b0;
		wa       = tq_q;
		wd_z     = zt_q;
		wd_x     = xt_q;
		unique case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				mem_clr  = s_tvalid && kind_in == RQ_INIT;
			end
			ST_SWEEP: ra_a = QW'(sw_q);
			ST_WRT:   mem_we = 1'b1;
			ST_WRC: begin
				mem_we = 1'b1;
				wa     = cq_q;
				wd_z   = zc_q;
				wd_x   = xc_q;
			end
			default: ;
		endcase
	end

	stgate_colmem #(
		.DEPTH   (NQ),
		.WIDTH   (ROWS),
		.RST_OFS (0)
	) u_zmem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.ra_a   (ra_a),
		.ra_b   (ra_b),
		.rd_a   (z_rd_a),
		.rd_b   (z_rd_b),
		.we     (mem_we),
		.wa     (wa),
		.wd     (wd_z)
	);

	stgate_colmem #(
		.DEPTH   (NQ),
		.WIDTH   (ROWS),
		.RST_OFS (NQ)
	) u_xmem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.ra_a   (ra_a),
		.ra_b   (ra_b),
		.rd_a   (x_rd_a),
		.rd_b   (x_rd_b),
		.we     (mem_we),
		.wa     (wa),
		.wd     (wd_x)
	);

	// One primitive on the working columns
	assign prim     = prog_step(kind_q, stp_q);
	assign stp_last = prog_last(kind_q);

	always_comb begin
		zt_nx = zt_q;
		xt_nx = xt_q;
		zc_nx = zc_q;
		ph_nx = ph_q;
		unique case (prim)
			PR_H: begin
				ph_nx = ph_q ^ (xt_q & zt_q);
				zt_nx = xt_q;
				xt_nx = zt_q;
			end
			PR_P: begin
				ph_nx = ph_q ^ (xt_q & zt_q);
				zt_nx = zt_q ^ xt_q;
			end
			PR_CX: begin
				ph_nx = ph_q ^ (xc_q & zt_q & ~(xt_q ^ zc_q));
				xt_nx = xt_q ^ xc_q;
				zc_nx = zc_q ^ zt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			stp_q  <= '0;
			sw_q   <= '0;
			ph_q   <= '0;
			mvld_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (acc && kind_in == RQ_INIT) begin
				ph_q <= '0;
			end
			if (acc) begin
				sw_q <= '0;
			end else if (st_q == ST_SWEEP && sw_q != NR_V) begin
				sw_q <= sw_q + SW'(1);
			end
			if (st_q == ST_LOAD) begin
				stp_q <= '0;
			end else if (st_q == ST_EXEC) begin
				stp_q <= stp_q + STEP_W'(1);
				ph_q  <= ph_nx;
			end
			if (st_q == ST_FIN && (!mvld_q || m_tready)) begin
				mvld_q <= 1'b1;
			end else if (m_tready) begin
				mvld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= kind_in;
			tq_q   <= QW'(tq_in);
			cq_q   <= QW'(cq_in);
			row_q  <= RW'(row_in);
			rz_q   <= '0;
			rx_q   <= '0;
			rph_q  <= (kind_in == RQ_READ && row_ok) ? ph_q[RW'(row_in)] : 1'b0;
			bad_q  <= bad_in;
		end
		if (st_q == ST_LOAD) begin
			zt_q <= z_rd_a;
			xt_q <= x_rd_a;
			zc_q <= z_rd_b;
			xc_q <= x_rd_b;
		end else if (st_q == ST_EXEC) begin
			zt_q <= zt_nx;
			xt_q <= xt_nx;
			zc_q <= zc_nx;
		end
		// read data is registered in the column memory and belongs to the previous sweep address
		if (st_q == ST_SWEEP && sw_q != '0) begin
			rz_q[ROWB_IDX_W'(sw_q - SW'(1))] <= z_rd_a[row_q];
			rx_q[ROWB_IDX_W'(sw_q - SW'(1))] <= x_rd_a[row_q];
		end
		if (st_q == ST_FIN && (!mvld_q || m_tready)) begin
			mdata_q <= {{OUT_PAD_W{1'b0}}, rph_q, rx_q, rz_q};
			muser_q <= bad_q;
		end
	end

	assign m_tvalid   = mvld_q;
	assign m_tdata    = mdata_q;
	assign m_tuser[0] = muser_q;

	`SGE_ASSERT_NXT(a_read_sweeps, acc && kind_in == RQ_READ && !bad_in, st_q == ST_SWEEP, "valid read did not start a sweep")
	`SGE_ASSERT_NXT(a_bad_no_write, acc && bad_in, st_q == ST_FIN && !mem_we, "rejected transaction reached the memories")
	`SGE_ASSERT_IMP(a_step_bound, st_q == ST_EXEC, stp_q <= stp_last, "gate program stepped past its end")
	`SGE_ASSERT_NXT(a_fin_loads, st_q == ST_FIN && !mvld_q, mvld_q, "finished result not loaded into empty output")

endmodule

### rtl/core/stgate_colmem.sv
`timescale 1ns / 1ps
module stgate_colmem #(
	parameter int DEPTH   = 16,
	parameter int WIDTH   = 32,
	parameter int RST_OFS = 0,
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic [AW-1:0]    ra_a,
	input  logic [AW-1:0]    ra_b,
	output logic [WIDTH-1:0] rd_a,
	output logic [WIDTH-1:0] rd_b,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] dat_a_s1, dat_b_s1;
	logic [AW-1:0]    adr_a_s1, adr_b_s1;
	logic             vld_a_s1, vld_b_s1;

	// Identity column: a single bit at the column's address plus RST_OFS
	function automatic logic [WIDTH-1:0] rst_col(logic [AW-1:0] a);
		return WIDTH'(1) << (int'(a) + RST_OFS);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		dat_a_s1 <= mem[ra_a];
		dat_b_s1 <= mem[ra_b];
		adr_a_s1 <= ra_a;
		adr_b_s1 <= ra_b;
		vld_a_s1 <= vld_q[ra_a];
		vld_b_s1 <= vld_q[ra_b];
	end

	// Unwritten entries read as the identity tableau
	assign rd_a = vld_a_s1 ? dat_a_s1 : rst_col(adr_a_s1);
	assign rd_b = vld_b_s1 ? dat_b_s1 : rst_col(adr_b_s1);

endmodule

### sim/stabilizer_tableau_gate_engine_unit_tb.sv
`timescale 1ns / 1ps
module stabilizer_tableau_gate_engine_unit_tb;
	import stgate_pkg::*;

	localparam int NQ_TB         = 16;
	localparam int ROWS          = 2 * NQ_TB;
	localparam int WATCHDOG_MAX  = 5000;
	localparam int LONG_HOLD     = 400;
	localparam int TAIL_CYCLES   = 40;
	localparam int RANDOM_PHASE  = 275;
	localparam int EXP_DEPTH     = 2048;

	localparam logic [REQ_W-1:0] RQ_FIRST_UNKNOWN = 4'd9;
	localparam logic [REQ_W-1:0] RQ_LAST_CODE     = 4'd15;

	typedef struct packed {
		logic [ROWB_W-1:0] z_bits;
		logic [ROWB_W-1:0] x_bits;
		logic              phase;
		logic              bad;
	} row_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [REQ_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;

	// tableau copy: bit k of a column belongs to row k
	logic [ROWS-1:0] z_col [NQ_TB];
	logic [ROWS-1:0] x_col [NQ_TB];
	logic [ROWS-1:0] phase_col;

	// expected results in transaction order
	row_result_t expected_rows [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	int mismatches = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int rx_hold_left = 0;
	int quiet_cycles = 0;

	stabilizer_tableau_gate_engine_unit #(.NQ(NQ_TB)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic void load_identity_tableau();
		for (int q = 0; q < NQ_TB; q++) begin
			z_col[q] = '0;
			x_col[q] = '0;
			z_col[q][q] = 1'b1;
			x_col[q][q + NQ_TB] = 1'b1;
		end
		phase_col = '0;
	endfunction

	function automatic void apply_had(logic [QF_W-1:0] q);
		logic [ROWS-1:0] held;
		phase_col ^= x_col[q] & z_col[q];
		held = z_col[q];
		z_col[q] = x_col[q];
		x_col[q] = held;
	endfunction

	function automatic void apply_phase(logic [QF_W-1:0] q);
		phase_col ^= x_col[q] & z_col[q];
		z_col[q] ^= x_col[q];
	endfunction

	function automatic void apply_cnot(logic [QF_W-1:0] c, logic [QF_W-1:0] t);
		phase_col ^= x_col[c] & z_col[t] & ~(x_col[t] ^ z_col[c]);
		x_col[t] ^= x_col[c];
		z_col[c] ^= z_col[t];
	endfunction

	function automatic void apply_pauli_x(logic [QF_W-1:0] q);
		apply_had(q);
		apply_phase(q);
		apply_phase(q);
		apply_had(q);
	endfunction

	// Advance the tableau copy by one request and return the row it reports
	function automatic row_result_t apply_request(logic [REQ_W-1:0] kind, logic [QF_W-1:0] tq,
			logic [QF_W-1:0] cq, logic [ROW_F_W-1:0] row);
		row_result_t res;
		res = '0;
		case (kind)
			RQ_H, RQ_P, RQ_X, RQ_Y, RQ_Z: begin
				if (int'(tq) >= NQ_TB) begin
					res.bad = 1'b1;
				end else if (kind == RQ_H) begin
					apply_had(tq);
				end else if (kind == RQ_P) begin
					apply_phase(tq);
				end else if (kind == RQ_X) begin
					apply_pauli_x(tq);
				end else if (kind == RQ_Y) begin
					apply_pauli_x(tq);
					apply_phase(tq);
					apply_phase(tq);
				end else begin
					apply_phase(tq);
					apply_phase(tq);
				end
			end
			RQ_CNOT, RQ_CZ: begin
				if (int'(tq) >= NQ_TB || int'(cq) >= NQ_TB || tq == cq) begin
					res.bad = 1'b1;
				end else if (kind == RQ_CNOT) begin
					apply_cnot(cq, tq);
				end else begin
					apply_had(tq);
					apply_cnot(cq, tq);
					apply_had(tq);
				end
			end
			RQ_INIT: load_identity_tableau();
			RQ_READ: begin
				if (int'(row) >= ROWS) begin
					res.bad = 1'b1;
				end else begin
					for (int q = 0; q < NQ_TB && q < ROWB_W; q++) begin
						res.z_bits[q] = z_col[q][row];
						res.x_bits[q] = x_col[q][row];
					end
					res.phase = phase_col[row];
				end
			end
			default: res.bad = 1'b1;
		endcase
		return res;
	endfunction

	// Offer one request and hold it until the engine accepts it
	task automatic send_request(logic [REQ_W-1:0] kind, logic [QF_W-1:0] tq,
			logic [QF_W-1:0] cq, logic [ROW_F_W-1:0] row);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, row, cq, tq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_rows[exp_wr % EXP_DEPTH] = apply_request(kind, tq, cq, row);
		exp_wr++;
	endtask

	task automatic wait_for_rows();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_rd != exp_wr)
			@(posedge clk);
	endtask

	task automatic send_random_request();
		int sel;
		logic [REQ_W-1:0]   kind;
		logic [QF_W-1:0]    tq;
		logic [QF_W-1:0]    cq;
		logic [ROW_F_W-1:0] row;
		sel  = $urandom_range(99);
		tq   = QF_W'($urandom_range(NQ_TB - 1));
		cq   = QF_W'($urandom_range(NQ_TB - 1));
		row  = ROW_F_W'($urandom_range(31));
		if (sel < 42) begin
			kind = REQ_W'($urandom_range(RQ_Z, RQ_H));
		end else if (sel < 64) begin
			kind = REQ_W'($urandom_range(RQ_CZ, RQ_CNOT));
			// keep most two-qubit gates legal; leave the odd clash through
			if (sel < 62 && cq == tq)
				cq = tq + QF_W'(1);
		end else if (sel < 94) begin
			kind = RQ_READ;
		end else if (sel < 96) begin
			kind = RQ_INIT;
		end else begin
			kind = REQ_W'($urandom_range(RQ_LAST_CODE, RQ_FIRST_UNKNOWN));
		end
		send_request(kind, tq, cq, row);
	endtask

	task automatic test_reset_tableau();
		send_request(RQ_READ, 4'd0, 4'd0, 5'd0);
		send_request(RQ_READ, 4'd15, 4'd15, 5'd15);
		send_request(RQ_READ, 4'd0, 4'd15, 5'd16);
		send_request(RQ_READ, 4'd15, 4'd0, 5'd31);
	endtask

	task automatic test_single_qubit_gates();
		send_request(RQ_H, 4'd0, 4'd15, 5'd31);
		send_request(RQ_P, 4'd0, 4'd0, 5'd0);
		send_request(RQ_X, 4'd15, 4'd0, 5'd0);
		send_request(RQ_Y, 4'd15, 4'd15, 5'd0);
		send_request(RQ_Z, 4'd7, 4'd3, 5'd0);
		send_request(RQ_READ, 4'd0, 4'd0, 5'd16);
		send_request(RQ_READ, 4'd0, 4'd0, 5'd31);
		send_request(RQ_READ, 4'd0, 4'd0, 5'd0);
	endtask

	task automatic test_two_qubit_gates();
		send_request(RQ_CNOT, 4'd15, 4'd0, 5'd0);
		send_request(RQ_CZ, 4'd0, 4'd15, 5'd0);
		send_request(RQ_CNOT, 4'd9, 4'd9, 5'd0);
		send_request(RQ_CZ, 4'd15, 4'd15, 5'd0);
		send_request(RQ_READ, 4'd0, 4'd0, 5'd15);
		send_request(RQ_READ, 4'd0, 4'd0, 5'd16);
	endtask

	task automatic test_reject_and_init();
		send_request(RQ_FIRST_UNKNOWN, 4'd3, 4'd5, 5'd2);
		send_request(RQ_LAST_CODE, 4'd15, 4'd15, 5'd31);
		send_request(RQ_INIT, 4'd0, 4'd0, 5'd0);
		send_request(RQ_READ, 4'd0, 4'd0, 5'd31);
		wait_for_rows();
	endtask

	task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count)
			send_random_request();
		wait_for_rows();
	endtask

	// Hold the output off while the sender keeps pushing, so the input backs up
	task automatic test_output_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_requests++;
		repeat (40)
			send_random_request();
		wait_for_rows();
	endtask

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			rx_hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		row_result_t want;
		row_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.z_bits = m_tdata[ROWB_W-1:0];
			got.x_bits = m_tdata[2*ROWB_W-1:ROWB_W];
			got.phase  = m_tdata[2*ROWB_W];
			got.bad    = m_tuser[0];
			if (exp_rd == exp_wr) begin
				$error("unexpected result transaction: tdata %h, tuser %b", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = expected_rows[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got.z_bits !== want.z_bits) begin
					$error("row_z_bits: expected %h, got %h", want.z_bits, got.z_bits);
					mismatches++;
				end
				if (got.x_bits !== want.x_bits) begin
					$error("row_x_bits: expected %h, got %h", want.x_bits, got.x_bits);
					mismatches++;
				end
				if (got.phase !== want.phase) begin
					$error("row_phase: expected %b, got %b", want.phase, got.phase);
					mismatches++;
				end
				if (got.bad !== want.bad) begin
					$error("bad_request: expected %b, got %b", want.bad, got.bad);
					mismatches++;
				end
			end
		end
	end

	// Abort when neither side has moved a transaction for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("stabilizer_tableau_gate_engine_unit_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		load_identity_tableau();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_tableau();
		test_single_qubit_gates();
		test_two_qubit_gates();
		test_reject_and_init();
		test_random_traffic(RANDOM_PHASE, 0, 0);
		test_random_traffic(RANDOM_PHASE, 73, 0);
		test_output_backpressure();
		test_random_traffic(RANDOM_PHASE, 0, 73);
		test_random_traffic(RANDOM_PHASE, 34, 34);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && exp_rd == exp_wr) begin
			$display("stabilizer_tableau_gate_engine_unit_tb: PASS");
		end else begin
			$display("stabilizer_tableau_gate_engine_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
